// ----- sv/tmc_pkg.sv -----
// Shared types and constants for the tile map text console.
// No dependencies; used by tmc_cursor, tmc_emitter and tilemap_text_console.
`default_nettype none

package tmc_pkg;

    localparam int MAP_SIZE     = 32;
    localparam int POS_W        = 5;
    localparam int INDEX_W      = 2 * POS_W;
    localparam int VISIBLE_ROWS = 20;
    localparam int LINE_WIDTH   = 30;

    localparam logic [7:0] NL_CODE       = 8'd10;
    localparam logic [3:0] PALETTE_RESET = 4'hF;

    localparam logic OP_PUT    = 1'b0;
    localparam logic OP_CURSOR = 1'b1;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SCROLL = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_TEXT_PALETTE = 1'b0;

    // work left for the emitter by one item
    typedef struct packed {
        logic               has_write;
        logic [INDEX_W-1:0] write_index;
        logic [7:0]         tile;
        logic [3:0]         palette;
        logic               has_scroll;
        logic [POS_W-1:0]   clear_row;
        logic [7:0]         scroll_ofs;
    } desc_t;

endpackage

`default_nettype wire

// ----- sv/tmc_cursor.sv -----
// Cursor and scroll state of the text console; builds the result descriptor
// for each item. Depends on tmc_pkg.
`default_nettype none

module tmc_cursor (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      accept,
    input  wire logic                      opcode,
    input  wire logic [7:0]                char_code,
    input  wire logic [tmc_pkg::POS_W-1:0] cursor_col,
    input  wire logic [tmc_pkg::POS_W-1:0] cursor_row,
    input  wire logic [3:0]                palette,
    output tmc_pkg::desc_t                 desc,
    output logic                           desc_req
);

    logic [tmc_pkg::POS_W-1:0] col_reg, col_next;
    logic [tmc_pkg::POS_W-1:0] row_reg, row_next;
    logic [tmc_pkg::POS_W-1:0] scroll_reg, scroll_next;

    logic [tmc_pkg::POS_W:0]   col_inc;
    logic [tmc_pkg::POS_W-1:0] row_inc;
    logic [tmc_pkg::POS_W-1:0] bottom_row;
    logic [tmc_pkg::POS_W-1:0] scroll_inc;
    logic                      is_nl;
    logic                      line_full;
    logic                      start_line;
    logic                      do_scroll;

    always_comb begin
        col_inc    = {1'b0, col_reg} + (tmc_pkg::POS_W+1)'(1);
        row_inc    = row_reg + tmc_pkg::POS_W'(1);
        bottom_row = scroll_reg + tmc_pkg::POS_W'(tmc_pkg::VISIBLE_ROWS);
        scroll_inc = scroll_reg + tmc_pkg::POS_W'(1);
        is_nl      = (char_code == tmc_pkg::NL_CODE);
        line_full  = (col_inc >= (tmc_pkg::POS_W+1)'(tmc_pkg::LINE_WIDTH)) ||
                     (col_inc == (tmc_pkg::POS_W+1)'(tmc_pkg::MAP_SIZE));
        start_line = (opcode == tmc_pkg::OP_PUT) && (is_nl || line_full);
        do_scroll  = start_line && (row_inc == bottom_row);

        desc.has_write   = (opcode == tmc_pkg::OP_PUT) && !is_nl;
        desc.write_index = {row_reg, col_reg};
        desc.tile        = char_code;
        desc.palette     = palette;
        desc.has_scroll  = do_scroll;
        desc.clear_row   = row_inc;
        desc.scroll_ofs  = {scroll_inc, 3'b000};
        desc_req         = desc.has_write || do_scroll;

        col_next    = col_reg;
        row_next    = row_reg;
        scroll_next = scroll_reg;
        if (opcode == tmc_pkg::OP_CURSOR) begin
            col_next = cursor_col;
            row_next = cursor_row + scroll_reg;
        end else begin
            if (!is_nl) begin
                col_next = col_inc[tmc_pkg::POS_W-1:0];
            end
            if (start_line) begin
                col_next = '0;
                row_next = row_inc;
            end
            if (do_scroll) begin
                scroll_next = scroll_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= '0;
            row_reg    <= '0;
            scroll_reg <= '0;
        end else if (accept) begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            scroll_reg <= scroll_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/tmc_emitter.sv -----
// Result sequencer: holds one descriptor and steps it out as map writes,
// row clears and a scroll update through a registered output. Depends on tmc_pkg.
`default_nettype none

module tmc_emitter (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        desc_load,
    input  wire tmc_pkg::desc_t              desc_in,
    output logic                             take_ready,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic                             m_kind,
    output logic [tmc_pkg::INDEX_W-1:0]      m_map_index,
    output logic [7:0]                       m_tile_number,
    output logic [3:0]                       m_palette_number,
    output logic [7:0]                       m_scroll_offset,
    output logic                             m_last
);

    typedef enum logic [1:0] {
        PH_WRITE,
        PH_CLEAR,
        PH_SCROLL
    } phase_t;

    phase_t                    phase_reg;
    logic                      busy_reg;
    logic [tmc_pkg::POS_W-1:0] clr_col_reg;
    tmc_pkg::desc_t            desc_reg;

    logic                      out_valid_reg;
    logic                      kind_reg;
    logic [tmc_pkg::INDEX_W-1:0] index_reg;
    logic [7:0]                tile_reg;
    logic [3:0]                pal_reg;
    logic [7:0]                ofs_reg;
    logic                      last_reg;

    logic                      out_free;
    logic                      step;
    logic                      cur_kind;
    logic [tmc_pkg::INDEX_W-1:0] cur_index;
    logic [7:0]                cur_tile;
    logic [3:0]                cur_pal;
    logic [7:0]                cur_ofs;
    logic                      cur_last;
    phase_t                    phase_next;

    always_comb begin
        out_free   = !out_valid_reg || m_ready;
        step       = busy_reg && out_free;
        cur_kind   = tmc_pkg::KIND_WRITE;
        cur_index  = '0;
        cur_tile   = '0;
        cur_pal    = '0;
        cur_ofs    = '0;
        cur_last   = 1'b0;
        phase_next = phase_reg;
        case (phase_reg)
            PH_WRITE: begin
                cur_index  = desc_reg.write_index;
                cur_tile   = desc_reg.tile;
                cur_pal    = desc_reg.palette;
                cur_last   = !desc_reg.has_scroll;
                phase_next = PH_CLEAR;
            end
            PH_CLEAR: begin
                cur_index = {desc_reg.clear_row, clr_col_reg};
                if (clr_col_reg == tmc_pkg::POS_W'(tmc_pkg::MAP_SIZE - 1)) begin
                    phase_next = PH_SCROLL;
                end
            end
            PH_SCROLL: begin
                cur_kind = tmc_pkg::KIND_SCROLL;
                cur_ofs  = desc_reg.scroll_ofs;
                cur_last = 1'b1;
            end
            default: begin
                cur_last = 1'b1;
            end
        endcase
        take_ready = !busy_reg || (step && cur_last);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            phase_reg     <= PH_WRITE;
            clr_col_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_free) begin
                out_valid_reg <= busy_reg;
            end
            if (step) begin
                kind_reg  <= cur_kind;
                index_reg <= cur_index;
                tile_reg  <= cur_tile;
                pal_reg   <= cur_pal;
                ofs_reg   <= cur_ofs;
                last_reg  <= cur_last;
                phase_reg <= phase_next;
                if (phase_reg == PH_CLEAR) begin
                    clr_col_reg <= clr_col_reg + tmc_pkg::POS_W'(1);
                end
                if (cur_last) begin
                    busy_reg <= 1'b0;
                end
            end
            if (desc_load) begin
                desc_reg    <= desc_in;
                busy_reg    <= 1'b1;
                phase_reg   <= desc_in.has_write ? PH_WRITE : PH_CLEAR;
                clr_col_reg <= '0;
            end
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_kind           = kind_reg;
    assign m_map_index      = index_reg;
    assign m_tile_number    = tile_reg;
    assign m_palette_number = pal_reg;
    assign m_scroll_offset  = ofs_reg;
    assign m_last           = last_reg;

endmodule

`default_nettype wire

// ----- sv/tilemap_text_console.sv -----
// Text console on a 32x32 wrapping tile map: top level with the palette
// register. Depends on tmc_pkg, tmc_cursor and tmc_emitter.
//
// Input channel (s_*): one command item per handshake. opcode 0 puts
// char_code (code 10 is a newline), opcode 1 moves the cursor to
// cursor_col and to cursor_row counted from the visible top.
// Result channel (m_*): map entry writes (kind 0) and scroll offset
// updates (kind 1); m_last marks the final result of an item.
// Cursor moves and newlines that do not scroll give no results.
// Throughput: one item per cycle while each gives at most one result and
// m_ready does not stall; a line that scrolls gives 34 results (or 33 for
// a newline code) at one per cycle, and s_ready stays low until the last
// of them is registered. A stalled m_ready holds the output item and,
// once the descriptor stage is occupied, s_ready. Configuration (APB,
// text_palette at address 0) must be written only while idle; the
// block itself does not enforce this.
// Reset (aresetn, synchronous, active low): cursor, row and scroll to zero,
// palette to 15, no results pending.
`default_nettype none

module tilemap_text_console (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [2:0]                     paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_opcode,
    input  wire logic [7:0]                     s_char_code,
    input  wire logic [tmc_pkg::POS_W-1:0]      s_cursor_col,
    input  wire logic [tmc_pkg::POS_W-1:0]      s_cursor_row,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic                                m_kind,
    output logic [tmc_pkg::INDEX_W-1:0]         m_map_index,
    output logic [7:0]                          m_tile_number,
    output logic [3:0]                          m_palette_number,
    output logic [7:0]                          m_scroll_offset,
    output logic                                m_last
);

    logic [3:0]     palette_reg;
    logic           cfg_write;
    logic           accept;
    logic           desc_req;
    logic           take_ready;
    tmc_pkg::desc_t desc;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == tmc_pkg::REG_TEXT_PALETTE);
    assign prdata    = (paddr[2] == tmc_pkg::REG_TEXT_PALETTE) ? {28'd0, palette_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            palette_reg <= tmc_pkg::PALETTE_RESET;
        end else if (cfg_write) begin
            palette_reg <= pwdata[3:0];
        end
    end

    assign s_ready = take_ready;
    assign accept  = s_valid && take_ready;

    tmc_cursor u_cursor (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .opcode     (s_opcode),
        .char_code  (s_char_code),
        .cursor_col (s_cursor_col),
        .cursor_row (s_cursor_row),
        .palette    (palette_reg),
        .desc       (desc),
        .desc_req   (desc_req)
    );

    tmc_emitter u_emitter (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .desc_load        (accept && desc_req),
        .desc_in          (desc),
        .take_ready       (take_ready),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_map_index      (m_map_index),
        .m_tile_number    (m_tile_number),
        .m_palette_number (m_palette_number),
        .m_scroll_offset  (m_scroll_offset),
        .m_last           (m_last)
    );

endmodule

`default_nettype wire
